[rtl/core/ttm_pkg.sv]
// ----------------------------------------------------------------------------
// ttm_pkg
// shared widths, item codes and types of the tick to millisecond converter
// ----------------------------------------------------------------------------
package ttm_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int TICK_BITS    = 28;
    localparam int MS_BITS      = 31;
    localparam int RATE_BITS    = 24;
    localparam int CFG_BITS     = 7;
    localparam int SEG_IDX_BITS = 6;
    localparam int SEG_BITS     = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = SEG_BITS + 1;

    localparam int US_PER_MS    = 1000;
    localparam logic [MS_BITS-1:0] MS_MAX = {MS_BITS{1'b1}};

    // scaled offsets at or above this give a quotient that no longer fits
    localparam longint unsigned SAT_LIMIT = 64'(US_PER_MS) << MS_BITS;
    localparam int PROD_BITS   = TICK_BITS + RATE_BITS;
    localparam int DIGIT_BITS  = 4;
    localparam int DIV_IN_BITS = $clog2(SAT_LIMIT);
    localparam int DIGITS      = (DIV_IN_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int DIV_BITS    = DIGITS * DIGIT_BITS;
    localparam int REM_BITS    = $clog2(US_PER_MS);
    localparam int PART_BITS   = REM_BITS + DIGIT_BITS;
    localparam int DCNT_BITS   = $clog2(DIGITS);

    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_CONVERT = 2'd1;
    localparam logic [1:0] MODE_REWIND  = 2'd2;
    localparam logic [1:0] MODE_CLEAR   = 2'd3;

    typedef struct packed {
        logic [TICK_BITS-1:0] tick;
        logic [MS_BITS-1:0]   ms;
        logic [RATE_BITS-1:0] rate;
    } t_seg;

    typedef struct packed {
        logic done;
        logic sat;
    } t_scale_sts;

endpackage

[rtl/core/ttm_scale.sv]
// ----------------------------------------------------------------------------
// ttm_scale
// multiplies a tick offset by the rate and divides by 1000, one radix-16
// digit per cycle, flagging quotients too large for the result field
// ----------------------------------------------------------------------------
module ttm_scale
    import ttm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [TICK_BITS-1:0] i_mag,
    input  logic [RATE_BITS-1:0] i_rate,
    output t_scale_sts           o_sts,
    output logic [MS_BITS-1:0]   o_quot
);

    localparam logic [1:0] SC_IDLE = 2'd0;
    localparam logic [1:0] SC_MUL  = 2'd1;
    localparam logic [1:0] SC_DIV  = 2'd2;

    logic [1:0]            r_phase;
    logic                  r_done;
    logic                  r_sat;
    logic [PROD_BITS-1:0]  r_prod;
    logic [DIV_BITS-1:0]   r_x;
    logic [REM_BITS-1:0]   r_rem;
    logic [MS_BITS-1:0]    r_quot;
    logic [DCNT_BITS-1:0]  r_cnt;

    logic [PART_BITS-1:0]  w_part;
    logic [DIGIT_BITS-1:0] w_digit;
    logic [REM_BITS-1:0]   w_rem;

    always_comb begin
        w_part  = {r_rem, r_x[DIV_BITS-1 -: DIGIT_BITS]};
        w_digit = '0;
        for (int k = 1; k < (1 << DIGIT_BITS); k++) begin
            if (w_part >= PART_BITS'(k * US_PER_MS)) begin
                w_digit = DIGIT_BITS'(k);
            end
        end
        w_rem = REM_BITS'(w_part - PART_BITS'(int'(w_digit) * US_PER_MS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= SC_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                SC_IDLE: begin
                    if (i_start) begin
                        r_phase <= SC_MUL;
                    end
                end
                SC_MUL: begin
                    r_phase <= SC_DIV;
                end
                SC_DIV: begin
                    if (r_cnt == DCNT_BITS'(DIGITS - 1)) begin
                        r_phase <= SC_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: begin
                    r_phase <= SC_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_phase)
            SC_MUL: begin
                r_prod <= PROD_BITS'(i_mag) * PROD_BITS'(i_rate);
                r_x    <= DIV_BITS'(PROD_BITS'(i_mag) * PROD_BITS'(i_rate));
                r_rem  <= '0;
                r_quot <= '0;
                r_cnt  <= '0;
            end
            SC_DIV: begin
                if (r_cnt == '0) begin
                    r_sat <= (64'(r_prod) >= SAT_LIMIT);
                end
                r_x    <= r_x << DIGIT_BITS;
                r_rem  <= w_rem;
                r_quot <= {r_quot[MS_BITS-DIGIT_BITS-1:0], w_digit};
                r_cnt  <= r_cnt + 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_sts.done = r_done;
    assign o_sts.sat  = r_sat;
    assign o_quot     = r_quot;

endmodule

[rtl/core/tick_to_millisecond_converter_core.sv]
// ----------------------------------------------------------------------------
// tick_to_millisecond_converter_core
// tempo map of segments in a synchronous memory; converts event ticks to
// milliseconds and keeps running maxima of time and tick
//
//   channel   signals                      direction
//   input     i_valid / o_stall, i_mode..  item in, accepted when idle
//   result    o_valid / i_stall, o_*       one item per convert item
//   config    i_cfg_we / i_cfg_data        segment count, write only
//
// load, rewind and clear items are done without leaving the idle state. a convert
// item walks the pointer forward over the segments it passes, one memory read
// per pointer step, then runs the 11 digit steps of the divide by 1000 in the
// scale unit. reset is synchronous and needs no clearing pass.
// a waiting result does not block load, rewind or clear items.
// ----------------------------------------------------------------------------
module tick_to_millisecond_converter_core
    import ttm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [1:0]              i_mode,
    input  logic [SEG_IDX_BITS-1:0] i_segment_index,
    input  logic [TICK_BITS-1:0]    i_segment_start_tick,
    input  logic [MS_BITS-1:0]      i_segment_start_ms,
    input  logic [RATE_BITS-1:0]    i_segment_us_per_tick,
    input  logic [TICK_BITS-1:0]    i_event_tick,
    input  logic                    i_cfg_we,
    input  logic [CFG_BITS-1:0]     i_cfg_data,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [MS_BITS-1:0]      o_event_ms,
    output logic [MS_BITS-1:0]      o_max_ms,
    output logic [TICK_BITS-1:0]    o_max_tick,
    output logic [SEG_IDX_BITS-1:0] o_segment_used
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WALK  = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;
    localparam logic [2:0] ST_ADD   = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    t_seg                  r_mem [MAX_SEGMENTS];
    t_seg                  r_rd_a;
    t_seg                  r_rd_b;

    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic [SEG_BITS-1:0]   r_cur;
    logic [SEG_BITS-1:0]   n_cur;
    logic [CFG_BITS-1:0]   r_seg_count;
    logic [MS_BITS-1:0]    r_max_ms;
    logic [TICK_BITS-1:0]  r_max_tick;
    logic                  r_out_valid;

    logic [TICK_BITS-1:0]  r_tick;
    logic                  r_neg;
    logic [TICK_BITS-1:0]  r_mag;
    logic [RATE_BITS-1:0]  r_rate;
    logic [MS_BITS-1:0]    r_base;
    logic [MS_BITS-1:0]    r_ms;
    logic [MS_BITS-1:0]    r_event_ms;
    logic [MS_BITS-1:0]    r_out_max_ms;
    logic [TICK_BITS-1:0]  r_out_max_tick;
    logic [SEG_BITS-1:0]   r_used;

    logic                  w_accept;
    logic                  w_out_free;
    logic [CNT_W-1:0]      w_used_count;
    logic [CNT_W-1:0]      w_next_idx;
    logic                  w_adv;
    logic [SEG_BITS-1:0]   w_addr_a;
    logic [SEG_BITS-1:0]   w_addr_b;
    logic [MS_BITS:0]      w_sum;
    logic [MS_BITS-1:0]    w_ms;
    logic [MS_BITS-1:0]    w_max_ms;
    logic [TICK_BITS-1:0]  w_max_tick;
    t_scale_sts            w_sts;
    logic [MS_BITS-1:0]    w_quot;

    ttm_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_START),
        .i_mag   (r_mag),
        .i_rate  (r_rate),
        .o_sts   (w_sts),
        .o_quot  (w_quot)
    );

    assign w_accept   = i_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_out_valid || !i_stall;

    always_comb begin
        if (r_seg_count == '0) begin
            w_used_count = CNT_W'(1);
        end else if (int'(r_seg_count) > MAX_SEGMENTS) begin
            w_used_count = CNT_W'(MAX_SEGMENTS);
        end else begin
            w_used_count = CNT_W'(r_seg_count);
        end
        w_next_idx = {1'b0, r_cur} + 1'b1;
        w_adv      = (w_next_idx < w_used_count) && (r_rd_b.tick <= r_tick);
    end

    always_comb begin
        n_state = r_state;
        n_cur   = r_cur;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && i_mode == MODE_CONVERT) begin
                    n_state = ST_WALK;
                end
                if (w_accept && i_mode == MODE_REWIND) begin
                    n_cur = '0;
                end
            end
            ST_WALK: begin
                if (w_adv) begin
                    n_cur = r_cur + 1'b1;
                end else begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (w_sts.done) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // pointer entry and its successor, read for the pointer value ahead
    assign w_addr_a = n_cur;
    assign w_addr_b = n_cur + 1'b1;

    always_ff @(posedge i_clk) begin
        if (w_accept && i_mode == MODE_LOAD && int'(i_segment_index) < MAX_SEGMENTS) begin
            r_mem[SEG_BITS'(i_segment_index)] <= '{tick: i_segment_start_tick,
                                                   ms:   i_segment_start_ms,
                                                   rate: i_segment_us_per_tick};
        end
        r_rd_a <= r_mem[w_addr_a];
        r_rd_b <= r_mem[w_addr_b];
    end

    always_comb begin
        w_sum = {1'b0, r_base} + {1'b0, w_quot};
        if (r_neg) begin
            if (w_sts.sat || w_quot > r_base) begin
                w_ms = '0;
            end else begin
                w_ms = r_base - w_quot;
            end
        end else begin
            if (w_sts.sat || w_sum[MS_BITS]) begin
                w_ms = MS_MAX;
            end else begin
                w_ms = w_sum[MS_BITS-1:0];
            end
        end
        w_max_ms   = (r_ms > r_max_ms) ? r_ms : r_max_ms;
        w_max_tick = (r_tick > r_max_tick) ? r_tick : r_max_tick;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cur       <= '0;
            r_seg_count <= CFG_BITS'(1);
            r_max_ms    <= '0;
            r_max_tick  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            if (i_cfg_we) begin
                r_seg_count <= i_cfg_data;
            end
            if (w_accept && i_mode == MODE_CLEAR) begin
                r_max_ms   <= '0;
                r_max_tick <= '0;
            end
            if (r_state == ST_FIN && w_out_free) begin
                r_out_valid <= 1'b1;
                r_max_ms    <= w_max_ms;
                r_max_tick  <= w_max_tick;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tick <= i_event_tick;
        end
        if (r_state == ST_WALK && !w_adv) begin
            r_neg  <= (r_tick < r_rd_a.tick);
            r_mag  <= (r_tick < r_rd_a.tick) ? (r_rd_a.tick - r_tick) : (r_tick - r_rd_a.tick);
            r_rate <= r_rd_a.rate;
            r_base <= r_rd_a.ms;
        end
        if (r_state == ST_ADD) begin
            r_ms <= w_ms;
        end
        if (r_state == ST_FIN && w_out_free) begin
            r_event_ms     <= r_ms;
            r_out_max_ms   <= w_max_ms;
            r_out_max_tick <= w_max_tick;
            r_used         <= r_cur;
        end
    end

    assign o_stall        = (r_state != ST_IDLE);
    assign o_valid        = r_out_valid;
    assign o_event_ms     = r_event_ms;
    assign o_max_ms       = r_out_max_ms;
    assign o_max_tick     = r_out_max_tick;
    assign o_segment_used = SEG_IDX_BITS'(r_used);

endmodule

[rtl/core/ttm_checker.sv]
// ----------------------------------------------------------------------------
// ttm_checker
// port level checks of the converter, attached to the top level by bind
// ----------------------------------------------------------------------------
module ttm_checker
    import ttm_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_valid,
    input logic                    o_stall,
    input logic [1:0]              i_mode,
    input logic                    o_valid,
    input logic                    i_stall,
    input logic [MS_BITS-1:0]      o_event_ms,
    input logic [MS_BITS-1:0]      o_max_ms,
    input logic [SEG_IDX_BITS-1:0] o_segment_used
);

    // running maximum already includes the item it is reported with
    a_max_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_max_ms >= o_event_ms))
        else $error("max_ms below event_ms");

    a_convert_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_mode == MODE_CONVERT) |=> o_stall)
        else $error("convert item did not hold the input side");

    a_other_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_mode != MODE_CONVERT) |=> !o_stall)
        else $error("non-convert item took more than one cycle");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without a convert item in progress");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_event_ms) && $stable(o_segment_used)))
        else $error("stalled result item changed");

endmodule

bind tick_to_millisecond_converter_core ttm_checker u_checker (.*);
